>>> design/broadcast_ring_buffer_core_defines.svh
// Assertion macros shared by the broadcast ring buffer RTL.
// Depends on nothing; files that assert pull this in with an include.
`ifndef BROADCAST_RING_BUFFER_CORE_DEFINES_SVH
`define BROADCAST_RING_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held
`define BRB_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/brb_pkg.sv
// Types and constants of the broadcast ring buffer.
// Depends on nothing; used by the core.
package brb_pkg;

    // Access kind carried in the input tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Fixed field widths of the stream words
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 3;
    localparam int READER_W    = 2;
    localparam int OUT_RDATA_W = 32;
    localparam int OUT_SLOT_W  = 2;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 2;

endpackage

>>> design/brb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module brb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/broadcast_ring_buffer_core.sv
// Broadcast ring buffer: SLOTS message slots, each read once by every one of READERS readers.
// The result word for an accepted word is registered and shown on the master side in the next cycle.
// Throughput: one word per cycle; the single result register and the registered RAM
// read set this, with the slave side ready whenever that register is empty or drained.
// Reset (i_rst_n low, synchronous): pointers, counters and done counts clear, all slots free;
// message contents are not cleared.
module broadcast_ring_buffer_core
    import brb_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int READERS    = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [31:0] data
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,   // [0] action, [2:1] reader
    // Master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] read_data, [33:32] slot,
                                                    // [34] slot_freed, [39:35] zero
    output logic [OUT_USER_W-1:0] o_m_axis_tuser    // [1:0] status
);

`include "broadcast_ring_buffer_core_defines.svh"

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int DW = $clog2(READERS + 1);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

    // Ring state
    logic [SW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_pending [READERS];
    logic [PW-1:0] n_pending [READERS];
    logic [SW-1:0] r_rptr    [READERS];
    logic [SW-1:0] n_rptr    [READERS];
    logic [DW-1:0] r_done    [SLOTS];
    logic [DW-1:0] n_done    [SLOTS];

    // Result register
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [OUT_SLOT_W-1:0] r_slot, n_slot;
    logic                  r_freed, n_freed;
    logic                  r_rd_ok, n_rd_ok;

    // Decode
    logic                  in_acc;
    logic                  is_wr;
    logic [READER_W-1:0]   reader;
    logic                  rd_in_range;
    logic [RW-1:0]         rd_idx;
    logic [SW-1:0]         rd_slot;
    logic [DW-1:0]         done_inc;
    logic                  rd_last;
    logic                  wr_ok;
    logic                  rd_ok;
    logic [DATA_WIDTH-1:0] ram_q;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_wr           = (i_s_axis_tuser[0] == ACT_WRITE);
    assign reader          = i_s_axis_tuser[READER_W:1];
    assign rd_in_range     = (32'(reader) < 32'(READERS));
    assign rd_idx          = RW'(reader);
    assign rd_slot         = r_rptr[rd_idx];
    assign done_inc        = r_done[rd_slot] + DW'(1);
    assign rd_last         = (done_inc >= DW'(READERS));
    assign wr_ok           = is_wr && (r_free != '0);
    assign rd_ok           = !is_wr && rd_in_range && (r_pending[rd_idx] != '0);

    // Message store
    brb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && wr_ok),
        .i_waddr (r_wptr),
        .i_wdata (DATA_WIDTH'(i_s_axis_tdata)),
        .i_re    (in_acc && rd_ok),
        .i_raddr (rd_slot),
        .o_rdata (ram_q)
    );

    // Next ring state
    always_comb begin
        n_wptr    = r_wptr;
        n_free    = r_free;
        n_pending = r_pending;
        n_rptr    = r_rptr;
        n_done    = r_done;
        if (in_acc && wr_ok) begin
            n_free = r_free - PW'(1);
            n_wptr = (r_wptr == SW'(SLOTS - 1)) ? '0 : r_wptr + SW'(1);
            for (int j = 0; j < READERS; j++) begin
                if (r_pending[j] < PW'(SLOTS)) begin
                    n_pending[j] = r_pending[j] + PW'(1);
                end
            end
        end else if (in_acc && rd_ok) begin
            n_pending[rd_idx] = r_pending[rd_idx] - PW'(1);
            n_rptr[rd_idx]    = (rd_slot == SW'(SLOTS - 1)) ? '0 : rd_slot + SW'(1);
            if (rd_last) begin
                n_done[rd_slot] = '0;
                if (r_free < PW'(SLOTS)) begin
                    n_free = r_free + PW'(1);
                end
            end else begin
                n_done[rd_slot] = done_inc;
            end
        end
    end

    // Next result
    always_comb begin
        n_valid  = r_valid && !i_m_axis_tready;
        n_status = r_status;
        n_slot   = r_slot;
        n_freed  = r_freed;
        n_rd_ok  = r_rd_ok;
        if (in_acc) begin
            n_valid = 1'b1;
            priority if (is_wr) begin
                n_status = wr_ok ? ST_OK : ST_FULL;
                n_slot   = wr_ok ? OUT_SLOT_W'(r_wptr) : '0;
                n_freed  = 1'b0;
                n_rd_ok  = 1'b0;
            end else begin
                n_status = rd_ok ? ST_OK : ST_EMPTY;
                n_slot   = rd_ok ? OUT_SLOT_W'(rd_slot) : '0;
                n_freed  = rd_ok && rd_last;
                n_rd_ok  = rd_ok;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wptr  <= '0;
            r_free  <= PW'(SLOTS);
            for (int j = 0; j < READERS; j++) begin
                r_pending[j] <= '0;
                r_rptr[j]    <= '0;
            end
            for (int k = 0; k < SLOTS; k++) begin
                r_done[k] <= '0;
            end
        end else begin
            r_valid   <= n_valid;
            r_wptr    <= n_wptr;
            r_free    <= n_free;
            r_pending <= n_pending;
            r_rptr    <= n_rptr;
            r_done    <= n_done;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_freed  <= n_freed;
        r_rd_ok  <= n_rd_ok;
    end

    // Drive the master side
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {(OUT_DATA_W - OUT_RDATA_W - OUT_SLOT_W - 1)'(0), r_freed, r_slot,
                              r_rd_ok ? OUT_RDATA_W'(ram_q) : OUT_RDATA_W'(0)};

    `BRB_ASSERT(a_free_range, 1'b1, r_free <= PW'(SLOTS), "free slot count above slot count")

    `BRB_ASSERT_NEXT(a_full_refused, in_acc && is_wr && (r_free == '0), r_status == ST_FULL,
        "write into a full ring not refused")

    `BRB_ASSERT_NEXT(a_write_takes_slot, in_acc && wr_ok, r_free == $past(r_free) - PW'(1),
        "accepted write did not take a slot")

    generate
        for (genvar g = 0; g < READERS; g++) begin : g_pend_chk
            `BRB_ASSERT(a_pending_bound, 1'b1, r_pending[g] <= PW'(SLOTS) - r_free,
                "reader has more pending than occupied slots")
        end
    endgenerate

endmodule
